### rtl/core/lome_pkg.sv
// Shared types and constants for the linked order move engine.
// Depends on nothing; imported by every module of the block except lome_link_ram.
package lome_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ID_W         = 11;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);

    typedef enum logic [1:0] {
        CMD_REBUILD,
        CMD_BEFORE,
        CMD_AFTER,
        CMD_QUERY
    } lome_cmd_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ_T,
        ST_QRESP,
        ST_WR1,
        ST_WR2,
        ST_WR3,
        ST_FINISH
    } lome_state_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
    } lome_ram_req_t;

    function automatic logic [ADDR_W-1:0] id_to_addr(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] a;
        a = id - ID_W'(1);
        return a[ADDR_W-1:0];
    endfunction

endpackage

### rtl/core/lome_link_ram.sv
// Generic synchronous RAM, one write port and one read port, read data registered.
// Depends on nothing; holds one link table of the engine.
module lome_link_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 11,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/lome_ctrl.sv
// Sequencer and datapath: reads, modifies and writes back the two link tables.
// Depends on lome_pkg; drives two lome_link_ram instances through request structs.
module lome_ctrl
    import lome_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      cmd,
    input  logic [ID_W-1:0] mover,
    input  logic [ID_W-1:0] target,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [ID_W-1:0] found_id,
    output logic            status,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] element_count,
    output lome_ram_req_t   succ_req,
    output lome_ram_req_t   pred_req,
    input  logic [ID_W-1:0] succ_rdata,
    input  logic [ID_W-1:0] pred_rdata
);

    lome_state_t       state_reg, state_next;
    logic [ID_W-1:0]   count_reg;
    logic [ID_W-1:0]   head_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              from_cmd_reg;
    logic              out_valid_reg;
    logic [ID_W-1:0]   found_id_reg;
    logic              status_reg;

    lome_cmd_t         cmd_reg;
    logic [ID_W-1:0]   s_reg;
    logic [ID_W-1:0]   t_reg;
    logic [ID_W-1:0]   p_reg;
    logic [ID_W-1:0]   n_reg;
    logic [ID_W-1:0]   anchor_reg;
    logic [ID_W-1:0]   res_found_reg;
    logic              res_status_reg;

    lome_cmd_t         cmd_in;
    logic              in_acc;
    logic              cfg_acc;
    logic              out_free;
    logic              move_ok;
    logic              sweep_last;
    logic              is_before;
    logic [ID_W-1:0]   sweep_id;
    logic [ID_W-1:0]   count_sat;
    logic [ID_W-1:0]   anchor_calc;

    assign cmd_in     = lome_cmd_t'(cmd);
    assign in_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign in_acc     = in_valid && in_ready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign is_before  = (cmd_reg == CMD_BEFORE);
    assign sweep_id   = ID_W'(sweep_reg) + ID_W'(1);
    assign sweep_last = (sweep_reg == id_to_addr(count_reg));

    assign out_valid  = out_valid_reg;
    assign found_id   = found_id_reg;
    assign status     = status_reg;

    assign move_ok = (mover != '0) && (mover <= count_reg)
                  && (target != '0) && (target <= count_reg)
                  && (mover != target);

    always_comb
    begin
        if (element_count == '0)
        begin
            count_sat = ID_W'(1);
        end
        else if (element_count > ID_W'(MAX_ELEMENTS))
        begin
            count_sat = ID_W'(MAX_ELEMENTS);
        end
        else
        begin
            count_sat = element_count;
        end
    end

    // Anchor link as seen after the unlink: the unlink may have rewritten it.
    always_comb
    begin
        if (is_before)
        begin
            anchor_calc = (t_reg == n_reg) ? p_reg : pred_rdata;
        end
        else
        begin
            anchor_calc = (t_reg == p_reg) ? n_reg : succ_rdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = from_cmd_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (cmd_in)
                        CMD_REBUILD: state_next = ST_SWEEP;
                        CMD_QUERY:   state_next = ST_QRESP;
                        CMD_BEFORE,
                        CMD_AFTER:   state_next = move_ok ? ST_READ_T : ST_FINISH;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_READ_T: state_next = ST_WR1;
            ST_QRESP:  state_next = ST_FINISH;
            ST_WR1:    state_next = ST_WR2;
            ST_WR2:    state_next = ST_WR3;
            ST_WR3:    state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        if (cfg_acc)
        begin
            state_next = ST_SWEEP;
        end
    end

    always_comb
    begin
        succ_req = '0;
        pred_req = '0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                succ_req.we    = 1'b1;
                succ_req.waddr = sweep_reg;
                succ_req.wdata = (sweep_id < count_reg) ? sweep_id + ID_W'(1) : '0;
                pred_req.we    = 1'b1;
                pred_req.waddr = sweep_reg;
                pred_req.wdata = sweep_id - ID_W'(1);
            end
            ST_IDLE:
            begin
                succ_req.re    = in_acc;
                succ_req.raddr = id_to_addr(mover);
                pred_req.re    = in_acc;
                pred_req.raddr = id_to_addr(mover);
            end
            ST_READ_T:
            begin
                succ_req.re    = 1'b1;
                succ_req.raddr = id_to_addr(t_reg);
                pred_req.re    = 1'b1;
                pred_req.raddr = id_to_addr(t_reg);
            end
            ST_WR1:
            begin
                succ_req.we    = (p_reg != '0);
                succ_req.waddr = id_to_addr(p_reg);
                succ_req.wdata = n_reg;
                pred_req.we    = (n_reg != '0);
                pred_req.waddr = id_to_addr(n_reg);
                pred_req.wdata = p_reg;
            end
            ST_WR2:
            begin
                succ_req.we    = 1'b1;
                succ_req.waddr = id_to_addr(s_reg);
                succ_req.wdata = is_before ? t_reg : anchor_reg;
                pred_req.we    = 1'b1;
                pred_req.waddr = id_to_addr(s_reg);
                pred_req.wdata = is_before ? anchor_reg : t_reg;
            end
            ST_WR3:
            begin
                if (is_before)
                begin
                    pred_req.we    = 1'b1;
                    pred_req.waddr = id_to_addr(t_reg);
                    succ_req.we    = (anchor_reg != '0);
                    succ_req.waddr = id_to_addr(anchor_reg);
                end
                else
                begin
                    succ_req.we    = 1'b1;
                    succ_req.waddr = id_to_addr(t_reg);
                    pred_req.we    = (anchor_reg != '0);
                    pred_req.waddr = id_to_addr(anchor_reg);
                end
                succ_req.wdata = s_reg;
                pred_req.wdata = s_reg;
            end
            ST_QRESP,
            ST_FINISH:
            begin
                succ_req = '0;
                pred_req = '0;
            end
            default:
            begin
                succ_req = '0;
                pred_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            count_reg     <= ID_W'(MAX_ELEMENTS);
            head_reg      <= ID_W'(1);
            sweep_reg     <= '0;
            from_cmd_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SWEEP)
            begin
                head_reg  <= ID_W'(1);
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (in_acc && cmd_in == CMD_REBUILD)
            begin
                sweep_reg    <= '0;
                from_cmd_reg <= 1'b1;
            end
            if (state_reg == ST_WR1 && p_reg == '0)
            begin
                head_reg <= n_reg;
            end
            if (state_reg == ST_WR3 && is_before && anchor_reg == '0)
            begin
                head_reg <= s_reg;
            end
            if (cfg_acc)
            begin
                count_reg    <= count_sat;
                sweep_reg    <= '0;
                from_cmd_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg        <= cmd_in;
            s_reg          <= mover;
            t_reg          <= target;
            res_found_reg  <= '0;
            res_status_reg <= (cmd_in == CMD_BEFORE || cmd_in == CMD_AFTER) && !move_ok;
        end
        if (state_reg == ST_QRESP)
        begin
            if (s_reg == '0)
            begin
                res_found_reg  <= head_reg;
                res_status_reg <= 1'b0;
            end
            else if (s_reg <= count_reg)
            begin
                res_found_reg  <= succ_rdata;
                res_status_reg <= 1'b0;
            end
            else
            begin
                res_found_reg  <= '0;
                res_status_reg <= 1'b1;
            end
        end
        if (state_reg == ST_READ_T)
        begin
            p_reg <= pred_rdata;
            n_reg <= succ_rdata;
        end
        if (state_reg == ST_WR1)
        begin
            anchor_reg <= anchor_calc;
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            found_id_reg <= res_found_reg;
            status_reg   <= res_status_reg;
        end
    end

endmodule

### rtl/core/linked_order_move_engine.sv
// Top level of the linked order move engine: sequencer plus successor and predecessor RAMs.
// Depends on lome_pkg, lome_ctrl and lome_link_ram.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    cmd, mover, target
//   out      source     out_valid / out_ready  found_id, status
//   cfg      sink       cfg_valid / cfg_ready  element_count
//
// One request at a time: a new request is accepted only in the idle state, after the
// previous one has finished. N is element_count saturated to 1..1024.
// Each move makes two reads and three write steps on the link RAMs.
// After reset, and after every cfg write, a sweep writes the identity chain
// for N entries (1024 after reset); in_ready and cfg_ready are low meanwhile.
// cfg is taken only while idle and wins over a request waiting in the same cycle.
// A waiting result does not block the next accept; the sequencer holds only
// when a new result is ready while the previous one is still stalled.
module linked_order_move_engine
    import lome_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      cmd,
    input  logic [ID_W-1:0] mover,
    input  logic [ID_W-1:0] target,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [ID_W-1:0] found_id,
    output logic            status,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] element_count
);

    lome_ram_req_t   succ_req;
    lome_ram_req_t   pred_req;
    logic [ID_W-1:0] succ_rdata;
    logic [ID_W-1:0] pred_rdata;

    lome_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .mover         (mover),
        .target        (target),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found_id      (found_id),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .element_count (element_count),
        .succ_req      (succ_req),
        .pred_req      (pred_req),
        .succ_rdata    (succ_rdata),
        .pred_rdata    (pred_rdata)
    );

    lome_link_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .WIDTH  (ID_W),
        .ADDR_W (ADDR_W)
    ) u_succ_ram (
        .clk   (clk),
        .we    (succ_req.we),
        .waddr (succ_req.waddr),
        .wdata (succ_req.wdata),
        .re    (succ_req.re),
        .raddr (succ_req.raddr),
        .rdata (succ_rdata)
    );

    lome_link_ram #(
        .DEPTH  (MAX_ELEMENTS),
        .WIDTH  (ID_W),
        .ADDR_W (ADDR_W)
    ) u_pred_ram (
        .clk   (clk),
        .we    (pred_req.we),
        .waddr (pred_req.waddr),
        .wdata (pred_req.wdata),
        .re    (pred_req.re),
        .raddr (pred_req.raddr),
        .rdata (pred_rdata)
    );

endmodule

### rtl/core/lome_checker.sv
// Port-level checks for the linked order move engine, bound to the top level.
// Depends on lome_pkg; sees only the ports of linked_order_move_engine.
module lome_checker
    import lome_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic [ID_W-1:0] found_id,
    input logic            status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_id) && $stable(status))
        else $error("result changed while stalled");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> found_id == '0)
        else $error("rejected request returned an id");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in progress");

    a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> found_id <= ID_W'(MAX_ELEMENTS))
        else $error("returned id out of range");

endmodule

bind linked_order_move_engine lome_checker u_lome_checker (.*);
